FILE: rtl/core/tmp_pkg.sv
package tmp_pkg;

  // Widths fixed by the external item format.
  localparam int FIELD_BITS     = 32;
  localparam int TICK_BITS      = 16;
  localparam int TOL_BITS       = 31;
  localparam int CFG_INDEX_BITS = 2;

  // Register reset values.
  localparam logic [TICK_BITS-1:0] TICK_PERIOD_RESET = 16'd66;
  localparam logic [TOL_BITS-1:0]  FINISH_TOL_RESET  = 31'd655;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TICK_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FINISH_TOL  = 2'd1;

  // Input item kinds.
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  // Profile phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ACCEL = 2'd1;
  localparam logic [1:0] PH_DECEL = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // Control from the sequencer to the shared multiplier.
  typedef struct packed {
    logic start;
    logic narrow;
  } tmp_mul_ctl_t;

endpackage

FILE: rtl/core/tmp_mul.sv
module tmp_mul #(
  parameter int WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tmp_pkg::tmp_mul_ctl_t  ctl,
  input  logic [WIDTH-1:0]       op_a,
  input  logic [WIDTH-1:0]       op_b,
  output logic                   done,
  output logic [2*WIDTH-1:0]     product
);
  import tmp_pkg::*;

  localparam int DIGITS        = (WIDTH + 3) / 4;
  localparam int PADW          = DIGITS * 4;
  localparam int CNTW          = $clog2(DIGITS);
  localparam int NARROW_DIGITS = TICK_BITS / 4;

  logic [WIDTH-1:0]   a_q;
  logic [PADW-1:0]    b_q;
  logic [CNTW-1:0]    cnt;
  logic               running;
  logic [2*WIDTH-1:0] acc;
  logic [3:0]         digit;
  logic [WIDTH+3:0]   pp;

  // Radix-16, most significant digit first: one digit of op_b per cycle.
  assign digit   = b_q[{cnt, 2'b00} +: 4];
  assign pp      = a_q * digit;
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
        cnt     <= ctl.narrow ? CNTW'(NARROW_DIGITS - 1) : CNTW'(DIGITS - 1);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_q <= op_a;
      b_q <= PADW'(op_b);
      acc <= '0;
    end else if (running) begin
      acc <= (acc << 4) + (2 * WIDTH)'(pp);
    end
  end

endmodule

FILE: rtl/core/trapezoidal_motion_profiler.sv
// A tick in the accelerating phase that runs the braking test also runs the speed ramp and
// the position step; other ticks outside the idle phase run the speed ramp and the step,
// and idle ticks and start, stop and finish transactions run only the step product.
// One item is taken at a time, as in_stall drops only after the result loads;
// the shared radix-16 multiplier runs every product in turn, one 4-bit digit per cycle.
// Reset (rst, synchronous, active high) clears the profile state, idles, and drops out_valid.
module trapezoidal_motion_profiler #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input item channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           kind,
  input  logic signed [tmp_pkg::FIELD_BITS-1:0] move_distance,
  input  logic signed [tmp_pkg::FIELD_BITS-1:0] peak_speed,
  input  logic signed [tmp_pkg::FIELD_BITS-1:0] end_speed,
  input  logic signed [tmp_pkg::FIELD_BITS-1:0] accel_rate,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tmp_pkg::FIELD_BITS-1:0] current_speed,
  output logic signed [tmp_pkg::FIELD_BITS-1:0] current_position,
  output logic signed [tmp_pkg::FIELD_BITS-1:0] step_distance,
  output logic [1:0]                           phase,
  output logic                                 done_res,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tmp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [tmp_pkg::FIELD_BITS-1:0]       cfg_data
);
  import tmp_pkg::*;

  // All profile words are signed W-bit values; SW is a working width wide enough to hold a
  // 32-bit input field or a position plus a step before saturation.
  localparam int W  = WORD_WIDTH;
  localparam int SW = ((W > FIELD_BITS) ? W : FIELD_BITS) + 3;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_M_END    = 4'd2;
  localparam logic [3:0] S_M_SPD    = 4'd3;
  localparam logic [3:0] S_M_REM    = 4'd4;
  localparam logic [3:0] S_M_DV     = 4'd5;
  localparam logic [3:0] S_M_STEP   = 4'd6;
  localparam logic [3:0] S_RESULT   = 4'd7;

  function automatic logic signed [W-1:0] sat_word(input logic signed [SW-1:0] x);
    if (x > SW'(WMAX)) begin
      return WMAX;
    end else if (x < SW'(WMIN)) begin
      return WMIN;
    end else begin
      return x[W-1:0];
    end
  endfunction

  // Magnitude, saturated so that the most negative word maps to the largest positive one.
  function automatic logic signed [W-1:0] mag_sat(input logic signed [W-1:0] x);
    if (x == WMIN) begin
      return WMAX;
    end else if (x < 0) begin
      return -x;
    end else begin
      return x;
    end
  endfunction

  // Exact magnitude as an unsigned word.
  function automatic logic [W-1:0] abs_word(input logic signed [W-1:0] x);
    return (x < 0) ? W'(-x) : W'(x);
  endfunction

  function automatic logic signed [W-1:0] by_dir(input logic dir,
                                                 input logic signed [W-1:0] m);
    return dir ? -m : m;
  endfunction

  // Configuration registers.
  logic [TICK_BITS-1:0] tick_period;
  logic [TOL_BITS-1:0]  finish_tolerance;

  // Profile state.
  logic signed [W-1:0] speed_reg;
  logic signed [W-1:0] position_reg;
  logic signed [W-1:0] goal_distance;
  logic signed [W-1:0] target_speed_reg;
  logic signed [W-1:0] end_speed_reg;
  logic signed [W-1:0] accel_reg;
  logic [1:0]          phase_reg;
  logic                direction;

  // Sequencer and working registers.
  logic [3:0]                    state;
  logic                          go;
  logic                          tick_live;
  logic [1:0]                    kind_q;
  logic signed [FIELD_BITS-1:0]  dist_q;
  logic signed [FIELD_BITS-1:0]  peak_q;
  logic signed [FIELD_BITS-1:0]  endsp_q;
  logic signed [FIELD_BITS-1:0]  acc_q;
  logic signed [W:0]             rem_reg;
  logic [2*W-1:0]                diff_reg;
  logic signed [W:0]             step_reg;

  // Shared multiplier.
  tmp_mul_ctl_t   mul_ctl;
  logic [W-1:0]   mul_a;
  logic [W-1:0]   mul_b;
  logic           mul_done;
  logic [2*W-1:0] mul_prod;

  // Combinational helpers.
  logic signed [W-1:0]         d_in;
  logic signed [W-1:0]         d_mag;
  logic signed [W-1:0]         vmax_in;
  logic signed [W-1:0]         vf_raw;
  logic signed [W-1:0]         vf_in;
  logic signed [W-1:0]         a_in;
  logic signed [SW-1:0]        tol_s;
  logic                        short_move;
  logic [W-1:0]                pos_mag;
  logic [W-1:0]                a_mag;
  logic signed [W:0]           rem;
  logic                        brake_now;
  logic [W-1:0]                dv;
  logic signed [W:0]           spd_inc;
  logic signed [W:0]           spd_dec;
  logic signed [W:0]           tgt_x;
  logic [W+TICK_BITS-1:0]      p_mag;
  logic signed [W+TICK_BITS:0] p_s;
  logic signed [W:0]           step_val;
  logic signed [W-1:0]         pos_new;
  logic                        slot_free;
  logic                        load_out;

  // One item is worked on at a time; a finished result waits in the output register while the
  // next transaction is taken, so in_stall depends only on the sequencer.
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || !out_stall;
  assign load_out  = (state == S_RESULT) && slot_free;

  // Start item decoding: every field is sign extended and saturated to the word range, the end
  // speed is capped at the peak speed, and the magnitudes take the sign of the move distance.
  assign d_in       = sat_word(SW'(dist_q));
  assign d_mag      = mag_sat(d_in);
  assign vmax_in    = sat_word(SW'(peak_q));
  assign vf_raw     = sat_word(SW'(endsp_q));
  assign vf_in      = (vf_raw > vmax_in) ? vmax_in : vf_raw;
  assign a_in       = sat_word(SW'(acc_q));
  assign tol_s      = SW'(signed'({1'b0, finish_tolerance}));
  assign short_move = SW'(d_mag) < tol_s;

  // Remaining distance to the goal; a negative value means the move overshot.
  assign pos_mag   = abs_word(position_reg);
  assign a_mag     = abs_word(accel_reg);
  assign rem       = signed'({1'b0, goal_distance}) - signed'({1'b0, pos_mag});
  assign brake_now = (a_mag == '0) || rem[W];

  // Speed ramp: the step is |accel| * tick_period with the tick fraction dropped.
  assign dv      = mul_prod[TICK_BITS +: W];
  assign spd_inc = (W+1)'(speed_reg) + signed'({1'b0, dv});
  assign spd_dec = (W+1)'(speed_reg) - signed'({1'b0, dv});
  assign tgt_x   = (W+1)'(target_speed_reg);

  // Distance per tick. The multiplier works on the speed magnitude, so the sign goes back on
  // before the arithmetic shift, which rounds toward minus infinity.
  assign p_mag    = mul_prod[W+TICK_BITS-1:0];
  assign p_s      = speed_reg[W-1] ? -signed'({1'b0, p_mag}) : signed'({1'b0, p_mag});
  assign step_val = (W+1)'(p_s >>> TICK_BITS);
  assign pos_new  = sat_word(SW'(position_reg) + SW'(step_val));

  // Operand selection for the shared multiplier. Operands are sampled in the cycle that go is
  // high, which is the first cycle of each multiply state.
  always_comb begin
    mul_ctl.start  = go;
    mul_ctl.narrow = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    unique case (state)
      S_M_END: begin
        mul_a = abs_word(end_speed_reg);
        mul_b = abs_word(end_speed_reg);
      end
      S_M_SPD: begin
        mul_a = abs_word(speed_reg);
        mul_b = abs_word(speed_reg);
      end
      S_M_REM: begin
        // Remaining distance times twice the acceleration magnitude.
        mul_a = rem_reg[W-1:0];
        mul_b = {a_mag[W-2:0], 1'b0};
      end
      S_M_DV: begin
        mul_ctl.narrow = 1'b1;
        mul_a          = a_mag;
        mul_b          = W'(tick_period);
      end
      S_M_STEP: begin
        mul_ctl.narrow = 1'b1;
        mul_a          = abs_word(speed_reg);
        mul_b          = W'(tick_period);
      end
      default: begin
        mul_ctl.narrow = 1'b0;
      end
    endcase
  end

  tmp_mul #(
    .WIDTH (W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mul_ctl),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Sequencer and profile state. An accelerating tick can walk through the braking test (end
  // speed squared, speed squared, remaining times twice the acceleration), the speed ramp,
  // and the position step. Every item ends with the step product, which also feeds step_distance.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      go               <= 1'b0;
      tick_live        <= 1'b0;
      out_valid        <= 1'b0;
      tick_period      <= TICK_PERIOD_RESET;
      finish_tolerance <= FINISH_TOL_RESET;
      speed_reg        <= '0;
      position_reg     <= '0;
      goal_distance    <= '0;
      target_speed_reg <= '0;
      end_speed_reg    <= '0;
      accel_reg        <= '0;
      phase_reg        <= PH_IDLE;
      direction        <= 1'b0;
    end else begin
      go <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TICK_PERIOD: tick_period      <= cfg_data[TICK_BITS-1:0];
          CFG_FINISH_TOL:  finish_tolerance <= cfg_data[TOL_BITS-1:0];
          default: begin
            tick_period <= tick_period;
          end
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            state <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          tick_live <= 1'b0;
          state     <= S_M_STEP;
          go        <= 1'b1;
          unique case (kind_q)
            KIND_TICK: begin
              if (phase_reg != PH_IDLE) begin
                tick_live <= 1'b1;
                if (phase_reg == PH_ACCEL && !brake_now) begin
                  state <= S_M_END;
                end else begin
                  // Zero acceleration or an overshoot brakes at once without the test.
                  if (phase_reg == PH_ACCEL) begin
                    phase_reg        <= PH_DECEL;
                    target_speed_reg <= end_speed_reg;
                  end
                  state <= S_M_DV;
                end
              end
            end
            KIND_START: begin
              direction <= d_in[W-1];
              // A move shorter than the tolerance only sets the direction and finishes.
              if (short_move) begin
                phase_reg <= PH_DONE;
              end else begin
                position_reg     <= '0;
                goal_distance    <= d_mag;
                target_speed_reg <= by_dir(d_in[W-1], mag_sat(vmax_in));
                end_speed_reg    <= by_dir(d_in[W-1], mag_sat(vf_in));
                accel_reg        <= by_dir(d_in[W-1], mag_sat(a_in));
                phase_reg        <= PH_ACCEL;
              end
            end
            KIND_STOP: begin
              target_speed_reg <= '0;
              speed_reg        <= '0;
              phase_reg        <= PH_DONE;
            end
            KIND_FINISH: begin
              speed_reg <= target_speed_reg;
              phase_reg <= PH_DONE;
            end
          endcase
        end

        S_M_END: begin
          if (mul_done) begin
            state <= S_M_SPD;
            go    <= 1'b1;
          end
        end

        S_M_SPD: begin
          if (mul_done) begin
            state <= S_M_REM;
            go    <= 1'b1;
          end
        end

        S_M_REM: begin
          if (mul_done) begin
            // Brake once the distance left is within the braking distance.
            if (mul_prod <= diff_reg) begin
              phase_reg        <= PH_DECEL;
              target_speed_reg <= end_speed_reg;
            end
            state <= S_M_DV;
            go    <= 1'b1;
          end
        end

        S_M_DV: begin
          if (mul_done) begin
            if (speed_reg < target_speed_reg) begin
              speed_reg <= (spd_inc > tgt_x) ? target_speed_reg : spd_inc[W-1:0];
            end else if (speed_reg > target_speed_reg) begin
              speed_reg <= (spd_dec < tgt_x) ? target_speed_reg : spd_dec[W-1:0];
            end
            state <= S_M_STEP;
            go    <= 1'b1;
          end
        end

        S_M_STEP: begin
          if (mul_done) begin
            if (tick_live) begin
              position_reg <= pos_new;
              if (phase_reg != PH_DONE && SW'(rem_reg) < tol_s) begin
                phase_reg        <= PH_DONE;
                target_speed_reg <= end_speed_reg;
              end
            end
            state <= S_RESULT;
          end
        end

        S_RESULT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working and output payload registers; these need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_q  <= kind;
      dist_q  <= move_distance;
      peak_q  <= peak_speed;
      endsp_q <= end_speed;
      acc_q   <= accel_rate;
    end
    if (state == S_DISPATCH) begin
      rem_reg <= rem;
    end
    if (state == S_M_END && mul_done) begin
      diff_reg <= mul_prod;
    end
    if (state == S_M_SPD && mul_done) begin
      // Absolute difference of the end speed squared and the speed squared.
      diff_reg <= (mul_prod >= diff_reg) ? (mul_prod - diff_reg) : (diff_reg - mul_prod);
    end
    if (state == S_M_STEP && mul_done) begin
      step_reg <= step_val;
    end
    if (load_out) begin
      current_speed    <= FIELD_BITS'(speed_reg);
      current_position <= FIELD_BITS'(position_reg);
      step_distance    <= FIELD_BITS'(step_reg);
      phase            <= phase_reg;
      done_res         <= (phase_reg == PH_DONE);
    end
  end

endmodule

FILE: rtl/core/tmp_chk.sv
module tmp_chk (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [tmp_pkg::FIELD_BITS-1:0] current_position,
  input logic [1:0]                            phase,
  input logic                                  done_res
);
  import tmp_pkg::*;

  // The done flag agrees with the reported phase whenever a result is valid.
  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (done_res == (phase == PH_DONE)))
    else $error("done_res does not match phase");

  // An accepted transaction occupies the block, so the next one must wait.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  // Reset leaves the block ready and with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(current_position) && $stable(phase)))
    else $error("stalled result changed");

endmodule

bind trapezoidal_motion_profiler tmp_chk u_tmp_chk (.*);
